>>> rtl/hnpt_pkg.sv
`default_nettype none
package hnpt_pkg;

    localparam int HOST_SLOTS = 16;
    localparam int NET_SLOTS  = 16;
    localparam int HIDX_W     = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
    localparam int NIDX_W     = (NET_SLOTS > 1) ? $clog2(NET_SLOTS) : 1;

    typedef logic [HIDX_W-1:0] t_hidx;
    typedef logic [NIDX_W-1:0] t_nidx;

    typedef logic [1:0] t_tag;
    localparam t_tag TAG_INVALID = 2'd0;
    localparam t_tag TAG_IPV4    = 2'd1;
    localparam t_tag TAG_IPV6    = 2'd2;

    typedef enum logic [2:0] {
        MODE_ADD_HOST   = 3'd0,
        MODE_ADD_NET    = 3'd1,
        MODE_CHECK      = 3'd2,
        MODE_CLEAR_HOST = 3'd3,
        MODE_CLEAR_NET  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    // request held stable for the whole walk down the chains
    typedef struct packed {
        t_mode       mode;
        t_tag        tag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  pfx;
    } t_req;

    // token handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  hit;
        logic  free_ok;
        t_hidx free_idx;
    } t_htok;

    typedef struct packed {
        logic  valid;
        logic  hit;
        logic  free_ok;
        t_nidx free_idx;
    } t_ntok;

    function automatic logic [7:0] clamp_prefix(input logic v6, input logic [7:0] p);
        logic [7:0] lim;
        lim = v6 ? 8'd128 : 8'd32;
        return (p > lim) ? lim : p;
    endfunction

    // network mask, upper half in bits 127..64; prefix already clamped
    function automatic logic [127:0] prefix_mask(input logic v6, input logic [7:0] pfx);
        logic [127:0] m;
        logic [31:0]  m4;
        m  = '0;
        m4 = '0;
        if (v6) begin
            if (pfx != 8'd0) m = {128{1'b1}} << (8'd128 - pfx);
        end else begin
            if (pfx != 8'd0) m4 = {32{1'b1}} << (6'd32 - pfx[5:0]);
            m = {96'h0, m4};
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> rtl/hnpt_host_cell.sv
`default_nettype none
module hnpt_host_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hnpt_pkg::t_hidx i_index,
    input  wire hnpt_pkg::t_req  i_req,
    input  wire hnpt_pkg::t_htok i_tok,
    input  wire logic           i_wr,
    output hnpt_pkg::t_htok     o_tok
);

    hnpt_pkg::t_tag  r_tag;
    logic [63:0]     r_hi;
    logic [63:0]     r_lo;
    hnpt_pkg::t_htok r_tok;
    hnpt_pkg::t_htok n_tok;
    logic            w_tag_eq;
    logic            w_match;

    assign w_tag_eq = (r_tag == i_req.tag);
    assign w_match  = w_tag_eq && (r_hi == i_req.hi) && (r_lo == i_req.lo);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            if (w_match) n_tok.hit = 1'b1;
            // lowest free slot wins: first invalid cell down the chain
            if (!i_tok.free_ok && (r_tag == hnpt_pkg::TAG_INVALID)) begin
                n_tok.free_ok  = 1'b1;
                n_tok.free_idx = i_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= hnpt_pkg::TAG_INVALID;
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_wr) begin
                r_tag <= i_req.tag;
            end else if (i_tok.valid && (i_req.mode == hnpt_pkg::MODE_CLEAR_HOST)
                         && w_tag_eq) begin
                r_tag <= hnpt_pkg::TAG_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_hi <= i_req.hi;
            r_lo <= i_req.lo;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

>>> rtl/hnpt_net_cell.sv
`default_nettype none
module hnpt_net_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hnpt_pkg::t_nidx i_index,
    input  wire hnpt_pkg::t_req  i_req,
    input  wire hnpt_pkg::t_ntok i_tok,
    input  wire logic           i_wr,
    output hnpt_pkg::t_ntok     o_tok
);

    hnpt_pkg::t_tag  r_tag;
    logic [63:0]     r_hi;
    logic [63:0]     r_lo;
    logic [7:0]      r_pfx;
    hnpt_pkg::t_ntok r_tok;
    hnpt_pkg::t_ntok n_tok;
    logic            w_tag_eq;
    logic            w_match;
    logic [127:0]    w_mask;

    assign w_tag_eq = (r_tag == i_req.tag);
    assign w_mask   = hnpt_pkg::prefix_mask(r_tag == hnpt_pkg::TAG_IPV6, r_pfx);

    always_comb begin
        // add compares the stored net itself, check tests containment
        if (i_req.mode == hnpt_pkg::MODE_ADD_NET) begin
            w_match = w_tag_eq && (r_hi == i_req.hi) && (r_lo == i_req.lo)
                      && (r_pfx == i_req.pfx);
        end else begin
            w_match = w_tag_eq && ((i_req.hi & w_mask[127:64]) == r_hi)
                      && ((i_req.lo & w_mask[63:0]) == r_lo);
        end
        n_tok = i_tok;
        if (i_tok.valid) begin
            if (w_match) n_tok.hit = 1'b1;
            if (!i_tok.free_ok && (r_tag == hnpt_pkg::TAG_INVALID)) begin
                n_tok.free_ok  = 1'b1;
                n_tok.free_idx = i_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= hnpt_pkg::TAG_INVALID;
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_wr) begin
                r_tag <= i_req.tag;
            end else if (i_tok.valid && (i_req.mode == hnpt_pkg::MODE_CLEAR_NET)
                         && w_tag_eq) begin
                r_tag <= hnpt_pkg::TAG_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_hi  <= i_req.hi;
            r_lo  <= i_req.lo;
            r_pfx <= i_req.pfx;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

>>> rtl/host_net_permit_table_unit.sv
// a request is registered, then its token walks the host and net chains side by side,
//   one cell per cycle; in the FIN state, once the output register is free, the result
//   is loaded into it, and no new request is taken before the block returns to idle
// reset: synchronous active low; all host and net tags invalid at once, no clearing pass
`default_nettype none
module host_net_permit_table_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_mode,
    input  wire logic        i_is_ipv6,
    input  wire logic [63:0] i_address_high,
    input  wire logic [63:0] i_address_low,
    input  wire logic [7:0]  i_prefix_length,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_success,
    output logic             o_table_full
);

    localparam int H = hnpt_pkg::HOST_SLOTS;
    localparam int N = hnpt_pkg::NET_SLOTS;

    hnpt_pkg::t_state r_state, n_state;
    hnpt_pkg::t_req   r_req, n_req;
    logic             r_launch;

    // token chains: entry 0 is the launch point, entry k the output of cell k-1
    hnpt_pkg::t_htok  w_htok [0:H];
    hnpt_pkg::t_ntok  w_ntok [0:N];
    hnpt_pkg::t_htok  r_host_res;
    hnpt_pkg::t_ntok  r_net_res;
    logic             r_host_done, r_net_done;
    logic [H-1:0]     w_host_wr;
    logic [N-1:0]     w_net_wr;

    logic             r_out_valid, r_success, r_full;
    logic             n_success, n_full;
    logic             w_accept, w_out_free, w_finish;
    logic             w_do_host_wr, w_do_net_wr;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_finish   = (r_state == hnpt_pkg::S_FIN) && w_out_free;

    // shape the incoming beat: drop upper bits for ipv4, clamp and mask nets
    always_comb begin
        logic         v6;
        logic [127:0] m;
        v6        = i_is_ipv6;
        n_req.mode = hnpt_pkg::t_mode'(i_mode);
        n_req.tag  = v6 ? hnpt_pkg::TAG_IPV6 : hnpt_pkg::TAG_IPV4;
        n_req.hi   = v6 ? i_address_high : 64'h0;
        n_req.lo   = v6 ? i_address_low : {32'h0, i_address_low[31:0]};
        n_req.pfx  = hnpt_pkg::clamp_prefix(v6, i_prefix_length);
        m          = hnpt_pkg::prefix_mask(v6, n_req.pfx);
        if (n_req.mode == hnpt_pkg::MODE_ADD_NET) begin
            n_req.hi = n_req.hi & m[127:64];
            n_req.lo = n_req.lo & m[63:0];
        end
    end

    // launch token enters both chains in the cycle after the beat
    assign w_htok[0] = '{valid: r_launch, hit: 1'b0, free_ok: 1'b0, free_idx: '0};
    assign w_ntok[0] = '{valid: r_launch, hit: 1'b0, free_ok: 1'b0, free_idx: '0};

    assign w_do_host_wr = w_finish && (r_req.mode == hnpt_pkg::MODE_ADD_HOST)
                          && !r_host_res.hit && r_host_res.free_ok;
    assign w_do_net_wr  = w_finish && (r_req.mode == hnpt_pkg::MODE_ADD_NET)
                          && !r_net_res.hit && r_net_res.free_ok;

    genvar g;
    generate
        for (g = 0; g < H; g++) begin : g_host
            assign w_host_wr[g] = w_do_host_wr
                                  && (r_host_res.free_idx == hnpt_pkg::t_hidx'(g));
            hnpt_host_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (hnpt_pkg::t_hidx'(g)),
                .i_req   (r_req),
                .i_tok   (w_htok[g]),
                .i_wr    (w_host_wr[g]),
                .o_tok   (w_htok[g+1])
            );
        end
        for (g = 0; g < N; g++) begin : g_net
            assign w_net_wr[g] = w_do_net_wr
                                 && (r_net_res.free_idx == hnpt_pkg::t_nidx'(g));
            hnpt_net_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (hnpt_pkg::t_nidx'(g)),
                .i_req   (r_req),
                .i_tok   (w_ntok[g]),
                .i_wr    (w_net_wr[g]),
                .o_tok   (w_ntok[g+1])
            );
        end
    endgenerate

    // next state and result
    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        n_success = 1'b0;
        n_full    = 1'b0;
        unique case (r_state)
            hnpt_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = hnpt_pkg::S_RUN;
            end
            hnpt_pkg::S_RUN: begin
                if ((r_host_done || w_htok[H].valid) && (r_net_done || w_ntok[N].valid))
                    n_state = hnpt_pkg::S_FIN;
            end
            hnpt_pkg::S_FIN: begin
                if (w_out_free) n_state = hnpt_pkg::S_IDLE;
            end
            default: n_state = hnpt_pkg::S_IDLE;
        endcase
        case (r_req.mode) inside
            hnpt_pkg::MODE_ADD_HOST: begin
                n_success = !r_host_res.hit && r_host_res.free_ok;
                n_full    = !r_host_res.hit && !r_host_res.free_ok;
            end
            hnpt_pkg::MODE_ADD_NET: begin
                n_success = !r_net_res.hit && r_net_res.free_ok;
                n_full    = !r_net_res.hit && !r_net_res.free_ok;
            end
            hnpt_pkg::MODE_CHECK: n_success = r_host_res.hit || r_net_res.hit;
            hnpt_pkg::MODE_CLEAR_HOST,
            hnpt_pkg::MODE_CLEAR_NET: n_success = 1'b1;
            default: ;   // unused modes answer zero and touch nothing
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hnpt_pkg::S_IDLE;
            r_launch    <= 1'b0;
            r_host_done <= 1'b0;
            r_net_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept;
            if (w_accept) begin
                r_host_done <= 1'b0;
                r_net_done  <= 1'b0;
            end else begin
                if (w_htok[H].valid) r_host_done <= 1'b1;
                if (w_ntok[N].valid) r_net_done  <= 1'b1;
            end
            // output register parts the chains from the result channel
            if (w_finish) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_req <= n_req;
        if (w_htok[H].valid) r_host_res <= w_htok[H];
        if (w_ntok[N].valid) r_net_res  <= w_ntok[N];
        if (w_finish) begin
            r_success <= n_success;
            r_full    <= n_full;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_success    = r_success;
    assign o_table_full = r_full;

`ifndef SYNTHESIS
    // no token may reach the chain ends while the block waits for a beat
    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hnpt_pkg::S_IDLE) |-> (!w_htok[H].valid && !w_ntok[N].valid))
        else $error("token in flight while idle");
    // an add writes at most one slot, and only in one table
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_host_wr, w_net_wr}))
        else $error("more than one slot written");
    // a refused add never reports success
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_success && o_table_full))
        else $error("success and table_full together");
    // a result is loaded only once both chains have reported
    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hnpt_pkg::S_FIN) |-> (r_host_done && r_net_done))
        else $error("finish before both chains done");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hnpt_pkg::*;

    // run shape
    localparam int POOL_SIZE     = 24;     // addresses that adds and checks keep reusing
    localparam int RANDOM_ITEMS  = 1200;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASES        = RANDOM_ITEMS / PHASE_ITEMS;
    localparam int STALL_LIMIT   = 2000;   // cycles with no beat on either side
    localparam int TAIL_CYCLES   = 50;     // longer than a pass through the pipeline
    localparam int SHOWN_MISSES  = 10;

    // mode codes the block leaves unused; they must answer with nothing done
    localparam logic [2:0] MODE_RESERVED_LO = 3'd5;
    localparam logic [2:0] MODE_RESERVED_HI = 3'd7;

    // mixes of operations used by the random phases
    localparam int PROF_MIX   = 0;   // everything, tables churn
    localparam int PROF_FILL  = 1;   // adds with no clears, drives the tables to full
    localparam int PROF_PROBE = 2;   // mostly address checks against what is stored

    typedef struct packed {
        logic success;
        logic table_full;
    } t_verdict;

    // permit table mirror: predicts one verdict per request beat and checks
    // the result beats against them in order
    class permit_scoreboard;
        bit [63:0] host_hi  [HOST_SLOTS];
        bit [63:0] host_lo  [HOST_SLOTS];
        bit [1:0]  host_tag [HOST_SLOTS];
        bit [63:0] net_hi   [NET_SLOTS];
        bit [63:0] net_lo   [NET_SLOTS];
        bit [7:0]  net_pfx  [NET_SLOTS];
        bit [1:0]  net_tag  [NET_SLOTS];

        t_verdict verdicts_due[$];

        int mismatches;
        int n_results;
        int n_added, n_dup, n_full, n_permit, n_deny, n_clear, n_unused;

        // prefix saturates at the width of the family
        static function bit [7:0] fit_prefix(bit v6, bit [7:0] p);
            bit [7:0] top;
            top = v6 ? 8'd128 : 8'd32;
            return (p > top) ? top : p;
        endfunction

        // leading p ones inside the family's width, upper half in 127..64
        static function bit [127:0] net_mask(bit v6, bit [7:0] p);
            bit [127:0] m;
            int         width;
            m     = '0;
            width = v6 ? 128 : 32;
            for (int b = 0; b < p; b++) m[width-1-b] = 1'b1;
            return m;
        endfunction

        function void note_request(bit [2:0] mode, bit v6, bit [63:0] ahi, bit [63:0] alo,
                                   bit [7:0] plen);
            bit [1:0]   tag;
            bit [63:0]  hi, lo;
            bit [7:0]   p;
            bit [127:0] m;
            int         free_at;
            bit         seen;
            t_verdict   v;
            tag     = v6 ? TAG_IPV6 : TAG_IPV4;
            hi      = v6 ? ahi : 64'h0;
            lo      = v6 ? alo : {32'h0, alo[31:0]};
            p       = fit_prefix(v6, plen);
            v       = '0;
            free_at = -1;
            seen    = 1'b0;
            case (mode)
                MODE_ADD_HOST: begin
                    for (int i = 0; i < HOST_SLOTS; i++) begin
                        if (host_tag[i] == tag && host_hi[i] == hi && host_lo[i] == lo)
                            seen = 1'b1;
                        if (host_tag[i] == TAG_INVALID && free_at < 0) free_at = i;
                    end
                    if (seen) begin
                        n_dup++;
                    end else if (free_at < 0) begin
                        v.table_full = 1'b1;
                        n_full++;
                    end else begin
                        host_hi[free_at]  = hi;
                        host_lo[free_at]  = lo;
                        host_tag[free_at] = tag;
                        v.success = 1'b1;
                        n_added++;
                    end
                end
                MODE_ADD_NET: begin
                    m  = net_mask(v6, p);
                    hi = hi & m[127:64];
                    lo = lo & m[63:0];
                    for (int i = 0; i < NET_SLOTS; i++) begin
                        if (net_tag[i] == tag && net_hi[i] == hi && net_lo[i] == lo &&
                            net_pfx[i] == p)
                            seen = 1'b1;
                        if (net_tag[i] == TAG_INVALID && free_at < 0) free_at = i;
                    end
                    if (seen) begin
                        n_dup++;
                    end else if (free_at < 0) begin
                        v.table_full = 1'b1;
                        n_full++;
                    end else begin
                        net_hi[free_at]  = hi;
                        net_lo[free_at]  = lo;
                        net_pfx[free_at] = p;
                        net_tag[free_at] = tag;
                        v.success = 1'b1;
                        n_added++;
                    end
                end
                MODE_CHECK: begin
                    for (int i = 0; i < HOST_SLOTS; i++)
                        if (host_tag[i] == tag && host_hi[i] == hi && host_lo[i] == lo)
                            v.success = 1'b1;
                    for (int i = 0; i < NET_SLOTS; i++) begin
                        if (net_tag[i] == tag) begin
                            m = net_mask(v6, net_pfx[i]);
                            if ((hi & m[127:64]) == net_hi[i] && (lo & m[63:0]) == net_lo[i])
                                v.success = 1'b1;
                        end
                    end
                    if (v.success) n_permit++;
                    else n_deny++;
                end
                MODE_CLEAR_HOST: begin
                    for (int i = 0; i < HOST_SLOTS; i++)
                        if (host_tag[i] == tag) host_tag[i] = TAG_INVALID;
                    v.success = 1'b1;
                    n_clear++;
                end
                MODE_CLEAR_NET: begin
                    for (int i = 0; i < NET_SLOTS; i++)
                        if (net_tag[i] == tag) net_tag[i] = TAG_INVALID;
                    v.success = 1'b1;
                    n_clear++;
                end
                default: n_unused++;
            endcase
            verdicts_due = {verdicts_due, v};
        endfunction

        function void check_verdict(logic success, logic table_full);
            t_verdict want;
            n_results++;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISSES)
                    $display("result %0d arrived with none due: success=%b table_full=%b",
                             n_results, success, table_full);
                return;
            end
            want = verdicts_due.pop_front();
            if (success !== want.success || table_full !== want.table_full) begin
                mismatches++;
                if (mismatches <= SHOWN_MISSES)
                    $display("result %0d: expected success=%b table_full=%b, got %b %b",
                             n_results, want.success, want.table_full, success, table_full);
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    // clock, reset and the block's inputs, all known from time zero
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        i_ready         = 1'b0;
    logic [2:0]  i_mode          = '0;
    logic        i_is_ipv6       = 1'b0;
    logic [63:0] i_address_high  = '0;
    logic [63:0] i_address_low   = '0;
    logic [7:0]  i_prefix_length = '0;
    logic        o_ready;
    logic        o_valid;
    logic        o_success;
    logic        o_table_full;

    permit_scoreboard sb;

    bit        quiet;              // set for phases with no idling on either side
    int        items_sent;
    int        idle_cycles;
    bit [63:0] pool_hi [POOL_SIZE];
    bit [63:0] pool_lo [POOL_SIZE];

    host_net_permit_table_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_is_ipv6       (i_is_ipv6),
        .i_address_high  (i_address_high),
        .i_address_low   (i_address_low),
        .i_prefix_length (i_prefix_length),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_success       (o_success),
        .o_table_full    (o_table_full)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // idle length for either side: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // one request beat; valid stays up with a fresh payload when no gap follows,
    // so valid is never dropped and raised in the same step
    task automatic send_item(input logic [2:0] mode, input logic v6, input logic [63:0] ahi,
                             input logic [63:0] alo, input logic [7:0] plen);
        int gap;
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_is_ipv6       <= v6;
        i_address_high  <= ahi;
        i_address_low   <= alo;
        i_prefix_length <= plen;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(mode, v6, ahi, alo, plen);
        items_sent++;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the sender off until every due result has come back;
    // always waits on the clock before it checks, so the next valid rises in a later step
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // random request drawn from the address pool so that duplicates, host hits
    // and prefix hits are frequent; a tenth of addresses are fresh noise
    task automatic send_random(input int profile);
        int         r, k, n, lim;
        int         cut [5];
        logic [2:0] mode;
        bit         v6;
        bit [127:0] addr, keep;
        bit [7:0]   plen;
        case (profile)
            PROF_FILL:  cut = '{45, 88, 99, 99, 99};
            PROF_PROBE: cut = '{10, 20, 92, 95, 98};
            default:    cut = '{25, 50, 88, 93, 98};
        endcase
        r = $urandom_range(0, 99);
        if (r < cut[0])      mode = MODE_ADD_HOST;
        else if (r < cut[1]) mode = MODE_ADD_NET;
        else if (r < cut[2]) mode = MODE_CHECK;
        else if (r < cut[3]) mode = MODE_CLEAR_HOST;
        else if (r < cut[4]) mode = MODE_CLEAR_NET;
        else                 mode = 3'($urandom_range(MODE_RESERVED_HI, MODE_RESERVED_LO));

        v6   = 1'($urandom_range(0, 1));
        lim  = v6 ? 128 : 32;
        k    = $urandom_range(0, POOL_SIZE - 1);
        addr = {pool_hi[k], pool_lo[k]};
        if ($urandom_range(0, 9) == 0) begin
            addr = {$urandom, $urandom, $urandom, $urandom};
        end else if (mode != MODE_ADD_HOST && $urandom_range(0, 1)) begin
            // keep the top n bits of the family and scramble the rest, so checks
            // land inside or just outside stored nets
            n = $urandom_range(0, lim);
            if (v6) keep = ~({128{1'b1}} >> n);
            else    keep = {{96{1'b1}}, ~(32'hffff_ffff >> n)};
            addr = (addr & keep) | ({$urandom, $urandom, $urandom, $urandom} & ~keep);
        end

        // prefix: zero and the top value now and then, IPv4 often past 32
        r = $urandom_range(0, 99);
        if (r < 4)                  plen = 8'd0;
        else if (r < 12)            plen = 8'd128;
        else if (!v6 && r < 30)     plen = 8'($urandom_range(33, 128));
        else                        plen = 8'($urandom_range(0, lim));

        send_item(mode, v6, addr[127:64], addr[63:0], plen);
    endtask

    // result side: check every result beat, stall ready at random
    initial begin : result_side
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) sb.check_verdict(o_success, o_table_full);
            if (stall == 0) stall = idle_len();
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        sb = new();
        quiet = 1'b0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_hi[k] = {$urandom, $urandom};
            pool_lo[k] = {$urandom, $urandom};
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        // empty tables permit nothing
        send_item(MODE_CHECK, 1'b0, 64'h0, 64'h0, 8'd0);
        // IPv4 host with every ignored bit set, then the same host with other
        // junk in the ignored bits is a duplicate
        send_item(MODE_ADD_HOST, 1'b0, '1, '1, 8'd0);
        send_item(MODE_ADD_HOST, 1'b0, 64'h0123_4567_89ab_cdef, 64'h5a5a_5a5a_ffff_ffff, 8'd0);
        send_item(MODE_CHECK, 1'b0, 64'hdead_beef_0000_0001, 64'h0000_0007_ffff_ffff, 8'd128);
        // same bits as IPv6 are a different family
        send_item(MODE_CHECK, 1'b1, 64'h0, 64'h0000_0000_ffff_ffff, 8'd0);
        // IPv6 hosts at both extremes
        send_item(MODE_ADD_HOST, 1'b1, '1, '1, 8'd0);
        send_item(MODE_ADD_HOST, 1'b1, 64'h0, 64'h0, 8'd0);
        send_item(MODE_CHECK, 1'b1, '1, '1, 8'd0);
        // IPv4 /8 stored masked, hit and miss
        send_item(MODE_ADD_NET, 1'b0, 64'h0, 64'h0000_0000_0a12_3456, 8'd8);
        send_item(MODE_CHECK, 1'b0, 64'h0, 64'h0000_0000_0a01_0203, 8'd0);
        send_item(MODE_CHECK, 1'b0, 64'h0, 64'h0000_0000_0b00_0000, 8'd0);
        // IPv4 prefix past 32 saturates, so /32 afterwards is a duplicate
        send_item(MODE_ADD_NET, 1'b0, 64'h0, 64'h0000_0000_c0a8_0101, 8'd128);
        send_item(MODE_ADD_NET, 1'b0, 64'h0, 64'h0000_0000_c0a8_0101, 8'd32);
        // IPv6 prefix zero permits any IPv6 address
        send_item(MODE_ADD_NET, 1'b1, 64'h2001_0db8_aaaa_bbbb, 64'h1111_2222_3333_4444, 8'd0);
        send_item(MODE_CHECK, 1'b1, 64'h3fff_0000_1234_5678, 64'h9abc_def0_1357_9bdf, 8'd0);
        send_item(MODE_ADD_NET, 1'b1, 64'h2001_0db8_0000_0001, 64'h0000_0000_0000_0042, 8'd128);
        send_item(MODE_ADD_NET, 1'b1, 64'h2001_0db8_0000_0001, 64'hffff_ffff_ffff_ffff, 8'd64);
        // clearing IPv6 nets leaves IPv4 nets and all hosts in place
        send_item(MODE_CLEAR_NET, 1'b1, 64'h0, 64'h0, 8'd0);
        send_item(MODE_CHECK, 1'b1, 64'h2001_0db8_0000_0001, 64'h0000_0000_0000_1234, 8'd0);
        send_item(MODE_CHECK, 1'b0, 64'h0, 64'h0000_0000_0a09_0909, 8'd0);
        // clearing IPv4 hosts leaves IPv6 hosts in place
        send_item(MODE_CLEAR_HOST, 1'b0, 64'h0, 64'h0, 8'd0);
        send_item(MODE_CHECK, 1'b0, 64'h0, 64'h0000_0000_ffff_ffff, 8'd0);
        send_item(MODE_CHECK, 1'b1, 64'h0, 64'h0, 8'd0);
        // unused mode codes
        send_item(MODE_RESERVED_LO, 1'b1, '1, '1, 8'd128);
        send_item(MODE_RESERVED_HI, 1'b0, 64'h0, 64'h0, 8'd0);
        drain();

        // random phases; every fourth one runs without idling, and every other
        // phase ends with the sender held off until the pipeline is empty
        for (int ph = 0; ph < PHASES; ph++) begin
            quiet = (ph % 4 == 3);
            for (int k = 0; k < 4; k++) begin
                pool_hi[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom};
                pool_lo[$urandom_range(0, POOL_SIZE - 1)] = {$urandom, $urandom};
            end
            repeat (PHASE_ITEMS) send_random(ph % 3);
            if (ph % 2 == 1 && ph != PHASES - 1) drain();
        end
        quiet = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d entries added, %0d duplicates, %0d refused on a full table",
                 items_sent, sb.n_added, sb.n_dup, sb.n_full);
        $display("%0d checks permitted, %0d denied, %0d clears, %0d unused modes, %0d results",
                 sb.n_permit, sb.n_deny, sb.n_clear, sb.n_unused, sb.n_results);
        if (sb.mismatches > SHOWN_MISSES)
            $display("%0d further mismatches not shown", sb.mismatches - SHOWN_MISSES);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/hnpt_pkg.sv
rtl/hnpt_host_cell.sv
rtl/hnpt_net_cell.sv
rtl/host_net_permit_table_unit.sv
tb/sv/tb_top.sv
